[sv/tdp_pkg.sv]
// Shared constants for the trial-division prime test unit.
`timescale 1ns / 1ps

package tdp_pkg;

	// Default width of the tested value, two's complement.
	localparam int unsigned VALUE_WIDTH_DEF = 32;

	// Smallest and largest widths the sequencer and divider are built for.
	localparam int unsigned VALUE_WIDTH_MIN = 8;
	localparam int unsigned VALUE_WIDTH_MAX = 64;

endpackage

[sv/tdp_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module tdp_div #(
	parameter int unsigned VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [VALUE_WIDTH-1:0] divisor,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] quot,
	output logic [VALUE_WIDTH-1:0] rem
);

	localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

	logic [VALUE_WIDTH-1:0] dvd_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;

	logic [VALUE_WIDTH:0] trial;
	logic [VALUE_WIDTH:0] diff;
	logic                 fits;

	// Shift the next dividend bit into the partial remainder, subtract if it fits.
	assign trial = {rem_q, dvd_q[VALUE_WIDTH-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_LAST;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: the dividend register fills with quotient bits as it empties.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VALUE_WIDTH-2:0], fits};
			rem_q <= fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
		end
	end

	assign done = done_q;
	assign quot = dvd_q;
	assign rem  = rem_q;

endmodule

[sv/trial_division_prime_test_unit.sv]
// Top level of the trial-division prime test unit: sequencer and result register.
`timescale 1ns / 1ps
//
// Usage
//   Input channel (cand_valid / cand_stall / candidate): one signed value per
//   transfer. Output channel (flag_valid / flag_stall / prime_flag): one flag
//   per input transfer, in the same order; 1 means the value is prime.
//   Values of one or less (every negative value included) report 0.
// Sequencing
//   One value is worked on at a time. Trivial values (below four, negative or
//   even) go from the sequencer to the output register without the divider.
//   Odd values try odd divisors from 3 upward, each through the bit-serial
//   divider, which sets the rate; k divisors are tried, k being at most
//   about sqrt(2^(VALUE_WIDTH-1)) / 2, roughly 23200 at the default width.
// Reset
//   arst_n clears the sequencer and the output valid; no flag is pending.
// Stall
//   A finished flag waits in the output register while flag_stall is high;
//   the next value may be transferred and worked on meanwhile, and its flag
//   holds in the sequencer until the output register is free.
//
module trial_division_prime_test_unit #(
	parameter int unsigned VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cand_valid,
	output logic                   cand_stall,
	input  logic [VALUE_WIDTH-1:0] candidate,
	output logic                   flag_valid,
	input  logic                   flag_stall,
	output logic                   prime_flag
);

	localparam logic [VALUE_WIDTH-1:0] TWO   = VALUE_WIDTH'(2);
	localparam logic [VALUE_WIDTH-1:0] THREE = VALUE_WIDTH'(3);
	localparam logic [VALUE_WIDTH-1:0] FOUR  = VALUE_WIDTH'(4);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] n_q;
	logic [VALUE_WIDTH-1:0] d_q;
	logic                   start_q;
	logic                   res_q;
	logic                   flag_valid_q;
	logic                   flag_q;

	logic                   div_done;
	logic [VALUE_WIDTH-1:0] div_quot;
	logic [VALUE_WIDTH-1:0] div_rem;

	logic cand_take;
	logic out_free;
	logic cand_trivial;
	logic run_stop;

	// Take a new value only while the sequencer is free.
	assign cand_stall = (state_q != ST_IDLE);
	assign cand_take  = cand_valid && !cand_stall;

	// The output register is free when empty or being drained this cycle.
	assign out_free = !flag_valid_q || !flag_stall;

	// Negative, small and even values are settled without the divider.
	assign cand_trivial = candidate[VALUE_WIDTH-1] || candidate < TWO ||
			candidate < FOUR || !candidate[0];

	// Stop once d exceeds n / d, or on an exact division.
	assign run_stop = d_q > div_quot || div_rem == '0;

	tdp_div #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (n_q),
		.divisor  (d_q),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			start_q      <= 1'b0;
			flag_valid_q <= 1'b0;
		end else begin
			// Kick the divider for the first divisor and for every further one.
			start_q <= (state_q == ST_IDLE && cand_take && !cand_trivial) ||
					(state_q == ST_RUN && div_done && !run_stop);
			// Load the output register when a flag is ready, drop it once drained.
			if (state_q == ST_DONE && out_free) begin
				flag_valid_q <= 1'b1;
			end else if (!flag_stall) begin
				flag_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cand_take) begin
						if (cand_trivial) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (div_done && run_stop) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Operands and result: no reset needed, qualified by the sequencer state.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cand_take) begin
					n_q <= candidate;
					d_q <= THREE;
					if (candidate[VALUE_WIDTH-1] || candidate < TWO) begin
						res_q <= 1'b0;
					end else if (candidate < FOUR) begin
						res_q <= 1'b1;
					end else begin
						res_q <= candidate[0];
					end
				end
			end
			ST_RUN: begin
				if (div_done) begin
					if (d_q > div_quot) begin
						res_q <= 1'b1;
					end else if (div_rem == '0) begin
						res_q <= 1'b0;
					end else begin
						d_q <= d_q + TWO;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					flag_q <= res_q;
				end
			end
			default: begin
				res_q <= 1'b0;
			end
		endcase
	end

	assign flag_valid = flag_valid_q;
	assign prime_flag = flag_q;

endmodule

[verif/prime_flag_checker.sv]
// Checker for the prime test unit: predicts each flag on input transfer and compares on output.
`timescale 1ns / 1ps

module prime_flag_checker #(
	parameter int unsigned VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cand_valid,
	input  logic                   cand_stall,
	input  logic [VALUE_WIDTH-1:0] candidate,
	input  logic                   flag_valid,
	input  logic                   flag_stall,
	input  logic                   prime_flag,
	output int                     errors,
	output int                     flags_pending
);

	typedef logic [VALUE_WIDTH-1:0] value_t;

	bit     flags_due[$];
	value_t values_due[$];
	bit     want_flag;
	value_t tested_value;

	// Trial division by 2 and then odd divisors; the bound d <= v / d cannot overflow.
	function automatic bit prime_by_trial(input value_t v);
		value_t d;
		if (v[VALUE_WIDTH-1])
			return 1'b0;
		if (v < 2)
			return 1'b0;
		if (v < 4)
			return 1'b1;
		if (!v[0])
			return 1'b0;
		for (d = 3; d <= v / d; d += 2)
			if (v % d == 0)
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic report_error(input string what);
		errors++;
		$display("%0t ns prime flag error: %s", $time, what);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (cand_valid && !cand_stall) begin
				flags_due.push_back(prime_by_trial(candidate));
				values_due.push_back(candidate);
			end
			if (flag_valid && !flag_stall) begin
				if (flags_due.size() == 0) begin
					report_error($sformatf("flag %b with no value outstanding", prime_flag));
				end else begin
					want_flag    = flags_due.pop_front();
					tested_value = values_due.pop_front();
					if (prime_flag !== want_flag)
						report_error($sformatf("value %0d: got %b, want %b",
							$signed(tested_value), prime_flag, want_flag));
				end
			end
			flags_pending <= flags_due.size();
		end
	end

endmodule

[verif/tb_trial_division_prime_test_unit.sv]
// Testbench top for the trial-division prime test unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_trial_division_prime_test_unit;

	localparam int unsigned VALUE_WIDTH    = tdp_pkg::VALUE_WIDTH_DEF;
	localparam int          CLK_PERIOD     = 10;
	localparam int          RESET_CYCLES   = 12;
	// Receiver hold-off length; the hold is requested while the block still
	// works on the top positive prime and ends before that item's flag is ready.
	localparam int          HOLD_CYCLES    = 300;
	localparam int          TAIL_CYCLES    = 50;
	// Sized for the largest single item, the top positive prime.
	localparam int          DRAIN_LIMIT    = 2_000_000;
	// Allow several times the slowest correct run.
	localparam int          TIMEOUT_CYCLES = 10_000_000;
	localparam int          RANDOM_ITEMS   = 100;
	localparam int          QUIET_ITEMS    = 20;

	typedef logic [VALUE_WIDTH-1:0] value_t;

	logic   clk        = 1'b0;
	logic   arst_n     = 1'b0;
	logic   cand_valid = 1'b0;
	value_t candidate  = '0;
	logic   flag_stall = 1'b0;
	logic   cand_stall;
	logic   flag_valid;
	logic   prime_flag;

	int     errors;
	int     flags_pending;

	// Random idle bursts on both channels; cleared for the directed part and the final stretch.
	bit     gaps_on  = 1'b0;
	// Raised by the stimulus to ask the receiver for one long hold-off; the receiver drops it.
	bit     hold_req = 1'b0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	trial_division_prime_test_unit #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cand_valid(cand_valid),
		.cand_stall(cand_stall),
		.candidate (candidate),
		.flag_valid(flag_valid),
		.flag_stall(flag_stall),
		.prime_flag(prime_flag)
	);

	prime_flag_checker #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cand_valid   (cand_valid),
		.cand_stall   (cand_stall),
		.candidate    (candidate),
		.flag_valid   (flag_valid),
		.flag_stall   (flag_stall),
		.prime_flag   (prime_flag),
		.errors       (errors),
		.flags_pending(flags_pending)
	);

	// Offer one value and return at the edge where it transfers. Valid stays
	// high on return, so back-to-back items never drop it; an idle burst
	// lowers it first and scrambles the payload while it is not valid.
	task automatic send(input value_t v);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			cand_valid <= 1'b0;
			candidate  <= value_t'($urandom);
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cand_valid <= 1'b1;
		candidate  <= v;
		do @(posedge clk); while (cand_stall);
	endtask

	// Drop valid and hold off until every predicted flag has come back or the
	// drain limit runs out. The checker's count is registered, so always advance first.
	task automatic wait_drained();
		int n;
		n = 0;
		cand_valid <= 1'b0;
		do begin
			@(posedge clk);
			n++;
		end while (flags_pending != 0 && n < DRAIN_LIMIT);
	endtask

	// Random values, weighted towards cheap items: a full-range odd prime
	// takes by far the longest, so odd values with no small factor
	// are kept below 2^18. Negative and even values exercise every bit at
	// full range, and multiples of a small odd prime give full-range
	// values that finish quickly.
	function automatic value_t random_value();
		int unsigned pick;
		int unsigned p;
		int unsigned q;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			return value_t'($urandom_range(0, 4095));
		if (pick < 45)
			return value_t'($urandom_range(0, 262143) | 1);
		if (pick < 60)
			return value_t'($urandom | 32'h8000_0000);
		if (pick < 75)
			return value_t'($urandom & 32'h7FFF_FFFE);
		if (pick < 90) begin
			case ($urandom_range(0, 4))
				0:       p = 3;
				1:       p = 5;
				2:       p = 7;
				3:       p = 11;
				default: p = 13;
			endcase
			return value_t'(p * $urandom_range(1, 32'h7FFF_FFFF / p));
		end
		// Odd squares land exactly on the loop bound d * d == n.
		q = $urandom_range(1, 255) * 2 + 1;
		return value_t'(q * q);
	endfunction

	// Receiver: random short stalls, or one long counted hold-off on request.
	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_req) begin
				flag_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				flag_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (gaps_on && $urandom_range(0, 4) == 0) begin
				flag_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				flag_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		int unsigned k;

		// Release reset on a clock edge; it is never asserted again.
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners: negatives, zero and one, the smallest primes and
		// composites, squares of primes right on the bound, and the top of
		// the positive range.
		send(32'h8000_0000);     // most negative value
		send(32'hFFFF_FFFF);     // minus one
		send(32'hAAAA_AAAA);     // negative, alternating bits
		send(32'd0);
		send(32'd1);
		send(32'd2);             // only even prime
		send(32'd3);
		send(32'd4);             // smallest composite, square of two
		send(32'd5);
		send(32'd9);             // square of the first odd divisor
		send(32'd25);
		send(32'd49);
		send(32'd63001);         // 251 squared
		send(32'd65521);         // prime just below 2^16
		send(32'd65537);         // prime just above 2^16
		send(32'h5555_5555);     // positive, alternating bits, multiple of five
		send(32'd2147483645);    // odd near the top, multiple of five
		send(32'h7FFF_FFFE);     // largest even value
		send(32'h7FFF_FFFF);     // largest positive value, itself a prime

		// Long receiver hold-off while small values are offered: the block is still
		// busy with the top positive prime, and the hold ends before any of them transfers.
		hold_req = 1'b1;
		for (k = 0; k < 8; k++)
			send(value_t'($urandom_range(0, 255)));

		// Sender pause: let every flag come home before the random part.
		wait_drained();

		// Random part with idle bursts on both sides, then a final stretch
		// with no idling at all.
		gaps_on = 1'b1;
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == RANDOM_ITEMS - QUIET_ITEMS)
				gaps_on = 1'b0;
			send(random_value());
		end

		// Drain, then watch a little longer for stray flags.
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0 && flags_pending == 0)
			$display("trial_division_prime_test_unit: match");
		else
			$display("trial_division_prime_test_unit: mismatch");
		$finish;
	end

	// Hard stop should the block hang.
	initial begin : watchdog
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("trial_division_prime_test_unit: mismatch");
		$finish;
	end

endmodule
